/* rtl/isc_pkg.sv */
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and fixed widths for the counted insertion sort chain.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam int VALUE_W = 32;
    localparam int CMP_W   = 11;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic               ins;    // insert ctl value into the chain
        logic               drain;  // shift the whole chain toward cell 0
        logic [VALUE_W-1:0] value;  // value being inserted
    } t_cell_ctl;

    // What one cell shows to its neighbors
    typedef struct packed {
        logic               valid;
        logic               gt;     // valid and held value > inserted value
        logic [VALUE_W-1:0] value;
    } t_cell_link;

endpackage

/* rtl/isc_cell.sv */
// ----------------------------------------------------------------------------
// isc_cell
// One slot of the sorted chain: holds a value, compares it against the value
// being inserted; takes left neighbor's value on insert, right one's on drain.
// ----------------------------------------------------------------------------
module isc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isc_pkg::t_cell_ctl  i_ctl,
    input  isc_pkg::t_cell_link i_prev,
    input  isc_pkg::t_cell_link i_next,
    output isc_pkg::t_cell_link o_link
);
    import isc_pkg::*;

    logic               r_valid;
    logic [VALUE_W-1:0] r_value;
    logic               w_gt;
    logic               w_take;

    // Compare held value against the incoming one (signed)
    assign w_gt   = r_valid && ($signed(r_value) > $signed(i_ctl.value));
    assign w_take = w_gt || !r_valid;

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

    // Hold, shift right on insert, or shift left on drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.drain) begin
            r_valid <= i_next.valid;
        end else if (i_ctl.ins && w_take) begin
            r_valid <= r_valid || i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_value <= i_next.value;
        end else if (i_ctl.ins && w_take) begin
            r_value <= i_prev.gt ? i_prev.value : i_ctl.value;
        end
    end

endmodule

/* rtl/insertion_sort_counted_core.sv */
// ----------------------------------------------------------------------------
// insertion_sort_counted_core
// Streaming insertion sort over a chain of DEPTH compare-and-shift cells with
// a running comparison count; emits the sorted set on the last request.
// ----------------------------------------------------------------------------
// A request is inserted into the cell chain when accepted; S_COUNT then
// updates the comparison count from the registered insertion point.
// A request with i_last then streams its n elements out of cell 0, one per
// cycle; busy stays high until the final one.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-low reset empties the chain and clears count and flag.
module insertion_sort_counted_core #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [isc_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_last,
    output logic                         o_strobe,
    output logic [isc_pkg::VALUE_W-1:0]  o_sorted_value,
    output logic [isc_pkg::CMP_W-1:0]    o_compare_total,
    output logic                         o_overflow,
    output logic                         o_final_res
);
    import isc_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   r_fill_before;
    logic [FILL_W-1:0]   r_remain;
    logic [CMP_W-1:0]    r_cmp;
    logic                r_dropped;
    logic                r_was_ins;
    logic                r_last;
    logic [DEPTH-1:0]    r_first;

    t_cell_ctl           w_ctl;
    t_cell_link          w_link [DEPTH];
    logic [DEPTH-1:0]    w_first;
    logic [IDX_W-1:0]    w_pos;
    logic                w_any;
    logic [FILL_W-1:0]   w_shifts;
    logic                w_accept;
    logic                w_room;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_room   = (r_fill < FILL_W'(DEPTH));

    // Broadcast command to the chain
    assign w_ctl.ins   = w_accept && w_room;
    assign w_ctl.drain = (r_state == S_EMIT);
    assign w_ctl.value = i_value;

    // Build the chain and mark where the greater-than run begins
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_link w_prev;
            t_cell_link w_next;
            if (gi == 0) begin : g_head
                assign w_prev.valid = 1'b1;
                assign w_prev.gt    = 1'b0;
                assign w_prev.value = '0;
                assign w_first[gi]  = w_link[gi].gt;
            end else begin : g_body
                assign w_prev      = w_link[gi-1];
                assign w_first[gi] = w_link[gi].gt && !w_link[gi-1].gt;
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign w_next.valid = 1'b0;
                assign w_next.gt    = 1'b0;
                assign w_next.value = '0;
            end else begin : g_inner
                assign w_next = w_link[gi+1];
            end
            isc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_link  (w_link[gi])
            );
        end
    endgenerate

    // Encode the registered one-hot insertion point
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_first[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_any    = |r_first;
    assign w_shifts = w_any ? (r_fill_before - FILL_W'(w_pos)) : FILL_W'(1);

    // Control: insert, count, then drain on the last request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cmp     <= '0;
            r_dropped <= 1'b0;
            r_remain  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if (r_was_ins && (r_fill_before != '0)) begin
                        r_cmp <= r_cmp + CMP_W'(w_shifts);
                    end
                    if (r_last) begin
                        r_remain <= r_fill;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    r_remain <= r_remain - FILL_W'(1);
                    if (r_remain == FILL_W'(1)) begin
                        r_fill    <= '0;
                        r_cmp     <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture request details for the count cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_was_ins     <= w_room;
            r_last        <= i_last;
            r_fill_before <= r_fill;
            r_first       <= w_first;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = (r_state == S_EMIT);
    assign o_sorted_value  = w_link[0].value;
    assign o_compare_total = r_cmp;
    assign o_overflow      = r_dropped;
    assign o_final_res     = (r_remain == FILL_W'(1));

endmodule

/* dv/insertion_sort_counted_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_counted_core_tb
// Drives sets of signed values into the counted insertion sort, one request
// per element, and checks every strobed result against a local model of the
// sorted store, comparison count and overflow flag. A short table of directed
// requests comes first, then random sets of mixed size, some past full depth.
// ----------------------------------------------------------------------------
module insertion_sort_counted_core_tb;

    import isc_pkg::*;

    localparam int DEPTH       = 64;
    localparam int N_RANDOM    = 380;
    localparam int CALM_TAIL   = 60;
    localparam int MAX_REPORTS = 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [VALUE_W-1:0] t_elem;

    // One sorted element as the block should strobe it
    typedef struct {
        t_elem            value;
        logic [CMP_W-1:0] total;
        logic             ovf;
        logic             fin;
    } t_sorted_elem;

    // One row of the directed table; typed rows carry their own result
    typedef struct {
        t_elem        value;
        logic         last;
        bit           typed;
        t_sorted_elem result;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [VALUE_W-1:0]   i_value;
    logic                 i_last;
    logic                 o_strobe;
    logic [VALUE_W-1:0]   o_sorted_value;
    logic [CMP_W-1:0]     o_compare_total;
    logic                 o_overflow;
    logic                 o_final_res;

    // Local copy of the sorting state
    t_elem            shadow_store [DEPTH];
    int               held_count;
    logic [CMP_W-1:0] compare_count;
    logic             dropped;

    t_sorted_elem pending_sorted[$];
    t_dir_row     dir_rows[$];
    int           error_count;
    int           cycle_count;

    insertion_sort_counted_core #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_value         (i_value),
        .i_last          (i_last),
        .o_strobe        (o_strobe),
        .o_sorted_value  (o_sorted_value),
        .o_compare_total (o_compare_total),
        .o_overflow      (o_overflow),
        .o_final_res     (o_final_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Insert one accepted element; on a last mark, queue the whole set
    // and clear. With typed set, the caller supplies the results instead.
    task automatic insert_and_emit(input t_elem v, input logic lst, input bit typed);
        int j;
        int shifts;
        t_sorted_elem r;
        if (held_count < DEPTH) begin
            j = held_count;
            shifts = 0;
            while (j > 0 && shadow_store[j-1] > v) begin
                shadow_store[j] = shadow_store[j-1];
                j--;
                shifts++;
            end
            shadow_store[j] = v;
            if (held_count > 0)
                compare_count = compare_count + CMP_W'(shifts > 0 ? shifts : 1);
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (lst) begin
            if (!typed) begin
                for (int k = 0; k < held_count; k++) begin
                    r.value = shadow_store[k];
                    r.total = compare_count;
                    r.ovf   = dropped;
                    r.fin   = (k == held_count - 1);
                    pending_sorted.push_back(r);
                end
            end
            held_count    = 0;
            compare_count = '0;
            dropped       = 1'b0;
        end
    endtask

    // Hold the request until the block takes it, then update the model
    task automatic send_request(input t_elem v, input logic lst, input bit typed);
        start   <= 1'b1;
        i_value <= v;
        i_last  <= lst;
        do @(posedge i_clk); while (busy);
        insert_and_emit(v, lst, typed);
    endtask

    // Drop start for a burst of idle cycles
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Mix full-range, clustered and extreme values so duplicates show up
    function automatic t_elem pick_value();
        case ($urandom_range(0, 9))
            5, 6:    return t_elem'($urandom_range(0, 7)) - 4;
            7:       return {1'b1, {(VALUE_W-1){1'b0}}};
            8:       return {1'b0, {(VALUE_W-1){1'b1}}};
            9:       return t_elem'($urandom_range(0, 2000)) - 1000;
            default: return t_elem'($urandom);
        endcase
    endfunction

    function automatic int pick_set_size(input int set_idx);
        int r;
        // force one overflowing set and one exactly full set early
        if (set_idx == 0) return DEPTH + 2;
        if (set_idx == 1) return DEPTH;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 8);
        if (r < 18) return $urandom_range(9, 40);
        if (r < 19) return $urandom_range(DEPTH - 4, DEPTH);
        return $urandom_range(DEPTH + 1, DEPTH + 8);
    endfunction

    // Directed requests: single-element sets at the extremes and around zero read off
    // directly; duplicates, descending and ascending runs go to the model
    task automatic load_dir_rows();
        t_elem mn;
        t_elem mx;
        mn = {1'b1, {(VALUE_W-1){1'b0}}};
        mx = {1'b0, {(VALUE_W-1){1'b1}}};
        dir_rows.push_back('{mn, 1'b1, 1'b1, '{mn, '0, 1'b0, 1'b1}});
        dir_rows.push_back('{mx, 1'b1, 1'b1, '{mx, '0, 1'b0, 1'b1}});
        dir_rows.push_back('{t_elem'(0), 1'b1, 1'b1, '{t_elem'(0), '0, 1'b0, 1'b1}});
        dir_rows.push_back('{t_elem'(-1), 1'b1, 1'b1, '{t_elem'(-1), '0, 1'b0, 1'b1}});
        // equal values and a mid-set insertion
        dir_rows.push_back('{t_elem'(5), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(5), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(-3), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(7), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(5), 1'b1, 1'b0, '{default: '0}});
        // strictly descending across the sign boundary
        dir_rows.push_back('{mx, 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(100), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(0), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(-1), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{mn, 1'b1, 1'b0, '{default: '0}});
        // ascending, then all equal
        dir_rows.push_back('{mn, 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(0), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{mx, 1'b1, 1'b0, '{default: '0}});
        dir_rows.push_back('{mx, 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{mx, 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{mx, 1'b1, 1'b0, '{default: '0}});
        // alternating bit patterns
        dir_rows.push_back('{t_elem'(32'hAAAA_AAAA), 1'b0, 1'b0, '{default: '0}});
        dir_rows.push_back('{t_elem'(32'h5555_5555), 1'b1, 1'b0, '{default: '0}});
    endtask

    // Main stimulus
    initial begin
        int sent;
        int set_idx;
        int set_size;
        bit gappy;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_value       = '0;
        i_last        = 1'b0;
        held_count    = 0;
        compare_count = '0;
        dropped       = 1'b0;
        error_count   = 0;
        load_dir_rows();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed)
                pending_sorted.push_back(dir_rows[i].result);
            send_request(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed);
            if (i % 7 == 3)
                idle_cycles($urandom_range(1, 19));
        end

        // random sets; no idling in the tail
        sent = 0;
        set_idx = 0;
        while (sent < N_RANDOM) begin
            set_size = pick_set_size(set_idx);
            gappy = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < set_size; k++) begin
                send_request(pick_value(), k == set_size - 1, 1'b0);
                sent++;
                if (gappy && sent < N_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 19));
            end
            set_idx++;
        end
        start <= 1'b0;

        // drain the remaining results, then let the block settle
        while (pending_sorted.size() > 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Compare each strobed result with the oldest expected element
    always @(posedge i_clk) begin
        t_sorted_elem e;
        if (i_rst_n && o_strobe) begin
            if (pending_sorted.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result value=%0d total=%0d ovf=%0b fin=%0b",
                             $realtime, $signed(o_sorted_value), o_compare_total,
                             o_overflow, o_final_res);
            end else begin
                e = pending_sorted.pop_front();
                if ($signed(o_sorted_value) !== e.value || o_compare_total !== e.total ||
                    o_overflow !== e.ovf || o_final_res !== e.fin) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp value=%0d total=%0d ovf=%0b fin=%0b, got value=%0d total=%0d ovf=%0b fin=%0b",
                                 $realtime, e.value, e.total, e.ovf, e.fin,
                                 $signed(o_sorted_value), o_compare_total,
                                 o_overflow, o_final_res);
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
